FILE: rtl/modular_arithmetic_unit_core_assert.svh
// Assertion macros shared by the checker of the modular arithmetic unit.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef MODULAR_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define MAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/mau_pkg.sv
// Shared constants of the modular arithmetic unit: widths, opcodes, reset modulus.
// Used by every module of the unit; depends on nothing.
package mau_pkg;

    localparam int RES_W  = 31;
    localparam int EXP_W  = 63;
    localparam int OP_W   = 3;
    localparam int STEP_W = $clog2(RES_W);

    localparam logic [RES_W-1:0] RESET_MODULUS = 31'd1000000007;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_POW = 3'd4;
    localparam logic [OP_W-1:0] OP_INV = 3'd5;

endpackage

FILE: rtl/mau_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on mau_pkg. Operands must already be below the modulus.
module mau_mulmod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mau_pkg::RES_W-1:0] i_x,
    input  logic [mau_pkg::RES_W-1:0] i_y,
    input  logic [mau_pkg::RES_W-1:0] i_mod,
    output logic                      o_done,
    output logic [mau_pkg::RES_W-1:0] o_prod
);

    logic                       r_busy;
    logic                       r_done;
    logic [mau_pkg::STEP_W-1:0] r_cnt;
    logic [mau_pkg::RES_W-1:0]  r_x;
    logic [mau_pkg::RES_W-1:0]  r_y;
    logic [mau_pkg::RES_W-1:0]  r_m;
    logic [mau_pkg::RES_W-1:0]  r_acc;

    logic [mau_pkg::RES_W:0]    dbl;
    logic [mau_pkg::RES_W:0]    dbl_red;
    logic [mau_pkg::RES_W:0]    sum;
    logic [mau_pkg::RES_W:0]    sum_red;

    // Double the partial product, reduce, add x if the bit is set, reduce
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        sum     = dbl_red + (r_y[mau_pkg::RES_W-1] ? {1'b0, r_x} : '0);
        sum_red = (sum >= {1'b0, r_m}) ? sum - {1'b0, r_m} : sum;
    end

    // Load on start, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_m    <= i_mod;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= sum_red[mau_pkg::RES_W-1:0];
                r_y   <= {r_y[mau_pkg::RES_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mau_pkg::STEP_W'(mau_pkg::RES_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/mau_divmod.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on mau_pkg. The divisor must be nonzero.
module mau_divmod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mau_pkg::RES_W-1:0] i_num,
    input  logic [mau_pkg::RES_W-1:0] i_den,
    output logic                      o_done,
    output logic [mau_pkg::RES_W-1:0] o_quo,
    output logic [mau_pkg::RES_W-1:0] o_rem
);

    logic                       r_busy;
    logic                       r_done;
    logic [mau_pkg::STEP_W-1:0] r_cnt;
    logic [mau_pkg::RES_W-1:0]  r_quo;
    logic [mau_pkg::RES_W-1:0]  r_rem;
    logic [mau_pkg::RES_W-1:0]  r_den;

    logic [mau_pkg::RES_W:0]    trial;
    logic                       fits;

    // Shift in the next numerator bit and try to subtract the divisor
    always_comb begin
        trial = {r_rem, r_quo[mau_pkg::RES_W-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    // Load on start, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? mau_pkg::RES_W'(trial - {1'b0, r_den}) :
                                trial[mau_pkg::RES_W-1:0];
                r_quo <= {r_quo[mau_pkg::RES_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mau_pkg::STEP_W'(mau_pkg::RES_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/modular_arithmetic_unit_core.sv
// Modular arithmetic unit: one item at a time; operands are reduced by a 31-step
// serial divider, products come from a 31-step serial multiplier.
// Add/sub need only the two reductions; multiply adds one product, power one or two
// products per exponent bit, inverse/divide a divide and a product per Euclid-like step.
// A new item is taken once the previous result has moved into the output register, which holds it.
// Reset (i_rst_n low, synchronous) empties the unit and sets the modulus to 1000000007.
module modular_arithmetic_unit_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [mau_pkg::RES_W-1:0] i_cfg_wdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // [2:0] opcode, [33:3] operand_a, [64:34] operand_b, [127:65] exponent
    input  logic [127:0]              i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // [30:0] result, [31] error
    output logic [31:0]               o_m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_DISP, S_INV_CHK, S_INV_DIV, S_INV_MUL,
        S_POW_CHK, S_POW_ACC, S_POW_SQ, S_MULF, S_DONE
    } t_state;

    t_state                       r_state;
    logic [mau_pkg::RES_W-1:0]    r_mod;
    logic [mau_pkg::OP_W-1:0]     r_op;
    logic [mau_pkg::RES_W-1:0]    r_a;
    logic [mau_pkg::RES_W-1:0]    r_b;
    logic [mau_pkg::EXP_W-1:0]    r_e;
    logic [mau_pkg::RES_W-1:0]    r_acc;
    logic [mau_pkg::RES_W-1:0]    r_sq;
    logic [mau_pkg::RES_W-1:0]    r_t;
    logic [mau_pkg::RES_W-1:0]    r_res;
    logic                         r_err;
    logic                         r_mstart;
    logic [mau_pkg::RES_W-1:0]    r_mx;
    logic [mau_pkg::RES_W-1:0]    r_my;
    logic                         r_dstart;
    logic [mau_pkg::RES_W-1:0]    r_dn;
    logic [mau_pkg::RES_W-1:0]    r_dd;
    logic                         r_out_valid;
    logic [mau_pkg::RES_W-1:0]    r_out_res;
    logic                         r_out_err;

    logic                         mul_done;
    logic [mau_pkg::RES_W-1:0]    mul_prod;
    logic                         div_done;
    logic [mau_pkg::RES_W-1:0]    div_quo;
    logic [mau_pkg::RES_W-1:0]    div_rem;

    logic [mau_pkg::OP_W-1:0]     in_op;
    logic [mau_pkg::RES_W-1:0]    in_a;
    logic [mau_pkg::RES_W-1:0]    in_b;
    logic [mau_pkg::EXP_W-1:0]    in_e;
    logic [mau_pkg::RES_W:0]      add_sum;
    logic [mau_pkg::RES_W:0]      sub_sum;

    assign in_op = i_s_tdata[2:0];
    assign in_a  = i_s_tdata[33:3];
    assign in_b  = i_s_tdata[64:34];
    assign in_e  = i_s_tdata[127:65];

    assign add_sum = {1'b0, r_a} + {1'b0, r_b};
    assign sub_sum = {1'b0, r_a} + {1'b0, r_mod - r_b};

    mau_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_mod   (r_mod),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mau_divmod u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dn),
        .i_den   (r_dd),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Hold the modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mau_pkg::RESET_MODULUS;
        end else if (i_cfg_wr_en) begin
            r_mod <= i_cfg_wdata;
        end
    end

    // Sequence the operation over the shared multiplier and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mstart    <= 1'b0;
            r_dstart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            // Drop a taken result unless a new one replaces it below
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op  <= in_op;
                        r_a   <= in_a;
                        r_b   <= in_b;
                        r_e   <= in_e;
                        r_res <= '0;
                        r_err <= 1'b0;
                        if (r_mod < 31'd2) begin
                            r_err   <= (in_op == mau_pkg::OP_DIV) ||
                                       (in_op == mau_pkg::OP_INV);
                            r_state <= S_DONE;
                        end else begin
                            r_dn     <= in_a;
                            r_dd     <= r_mod;
                            r_dstart <= 1'b1;
                            r_state  <= S_RDA;
                        end
                    end
                end
                S_RDA: begin
                    if (div_done) begin
                        r_a      <= div_rem;
                        r_dn     <= r_b;
                        r_dd     <= r_mod;
                        r_dstart <= 1'b1;
                        r_state  <= S_RDB;
                    end
                end
                S_RDB: begin
                    if (div_done) begin
                        r_b     <= div_rem;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_op)
                        mau_pkg::OP_ADD: begin
                            r_res   <= (add_sum >= {1'b0, r_mod}) ?
                                       mau_pkg::RES_W'(add_sum - {1'b0, r_mod}) :
                                       add_sum[mau_pkg::RES_W-1:0];
                            r_state <= S_DONE;
                        end
                        mau_pkg::OP_SUB: begin
                            r_res   <= (sub_sum >= {1'b0, r_mod}) ?
                                       mau_pkg::RES_W'(sub_sum - {1'b0, r_mod}) :
                                       sub_sum[mau_pkg::RES_W-1:0];
                            r_state <= S_DONE;
                        end
                        mau_pkg::OP_MUL: begin
                            r_mx     <= r_a;
                            r_my     <= r_b;
                            r_mstart <= 1'b1;
                            r_state  <= S_MULF;
                        end
                        mau_pkg::OP_DIV: begin
                            r_t     <= r_b;
                            r_acc   <= 31'd1;
                            r_state <= S_INV_CHK;
                        end
                        mau_pkg::OP_INV: begin
                            r_t     <= r_a;
                            r_acc   <= 31'd1;
                            r_state <= S_INV_CHK;
                        end
                        mau_pkg::OP_POW: begin
                            r_acc   <= 31'd1;
                            r_sq    <= r_a;
                            r_state <= S_POW_CHK;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                // Stop on zero (not invertible) or one (inverse found)
                S_INV_CHK: begin
                    if (r_t == '0) begin
                        r_err   <= 1'b1;
                        r_res   <= '0;
                        r_state <= S_DONE;
                    end else if (r_t == 31'd1) begin
                        if (r_op == mau_pkg::OP_DIV) begin
                            r_mx     <= r_a;
                            r_my     <= r_acc;
                            r_mstart <= 1'b1;
                            r_state  <= S_MULF;
                        end else begin
                            r_res   <= r_acc;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_dn     <= r_mod;
                        r_dd     <= r_t;
                        r_dstart <= 1'b1;
                        r_state  <= S_INV_DIV;
                    end
                end
                S_INV_DIV: begin
                    if (div_done) begin
                        r_t      <= div_rem;
                        r_mx     <= r_acc;
                        r_my     <= r_mod - div_quo;
                        r_mstart <= 1'b1;
                        r_state  <= S_INV_MUL;
                    end
                end
                S_INV_MUL: begin
                    if (mul_done) begin
                        r_acc   <= mul_prod;
                        r_state <= S_INV_CHK;
                    end
                end
                // Square-and-multiply, exponent LSB first
                S_POW_CHK: begin
                    if (r_e == '0) begin
                        r_res   <= r_acc;
                        r_state <= S_DONE;
                    end else if (r_e[0]) begin
                        r_mx     <= r_acc;
                        r_my     <= r_sq;
                        r_mstart <= 1'b1;
                        r_state  <= S_POW_ACC;
                    end else begin
                        r_mx     <= r_sq;
                        r_my     <= r_sq;
                        r_mstart <= 1'b1;
                        r_state  <= S_POW_SQ;
                    end
                end
                S_POW_ACC: begin
                    if (mul_done) begin
                        r_acc    <= mul_prod;
                        r_mx     <= r_sq;
                        r_my     <= r_sq;
                        r_mstart <= 1'b1;
                        r_state  <= S_POW_SQ;
                    end
                end
                S_POW_SQ: begin
                    if (mul_done) begin
                        r_sq    <= mul_prod;
                        r_e     <= {1'b0, r_e[mau_pkg::EXP_W-1:1]};
                        r_state <= S_POW_CHK;
                    end
                end
                S_MULF: begin
                    if (mul_done) begin
                        r_res   <= mul_prod;
                        r_state <= S_DONE;
                    end
                end
                // Move the result into the output register once it is free
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_res;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_err, r_out_res};

endmodule

FILE: rtl/mau_checker.sv
// Port-level checker for the modular arithmetic unit, bound to the top level.
// Depends on modular_arithmetic_unit_core_assert.svh.
`include "modular_arithmetic_unit_core_assert.svh"

module mau_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [31:0]  o_m_tdata
);

    // An error result always carries a zero residue
    `MAU_ASSERT_IMP(a_err_zero, o_m_tvalid && o_m_tdata[31], o_m_tdata[30:0] == 31'd0)

    // A residue is below the modulus, so never all ones
    `MAU_ASSERT_IMP(a_res_range, o_m_tvalid, o_m_tdata[30:0] != 31'h7FFFFFFF)

    // One item at a time: no new item right after one is taken
    `MAU_ASSERT_NXT(a_one_item, i_s_tvalid && o_s_tready, !o_s_tready)

    // A stalled result holds
    `MAU_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
